// ===== sv/clbc_pkg.sv =====
// ----------------------------------------------------------------------------
// clbc_pkg
// Shared types and constants for the card number brand and Luhn checker.
// ----------------------------------------------------------------------------
package clbc_pkg;

  localparam int unsigned CARD_W   = 54;
  localparam int unsigned BRAND_W  = 2;
  localparam int unsigned COUNT_W  = 5;
  // 2^54 - 1 has 17 decimal digits
  localparam int unsigned NUM_DIG  = 17;
  localparam int unsigned BCD_W    = NUM_DIG * 4;
  localparam int unsigned CNT_W    = 6;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CARD_W - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_DIG - 1);

  localparam logic [COUNT_W-1:0] LEN_VISA_SHORT = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] LEN_AMEX       = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] LEN_LONG       = COUNT_W'(16);

  typedef logic [BRAND_W-1:0] brand_t;

  localparam brand_t BRAND_INVALID = 2'd0;
  localparam brand_t BRAND_AMEX    = 2'd1;
  localparam brand_t BRAND_VISA    = 2'd2;
  localparam brand_t BRAND_MC      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } clbc_state_t;

endpackage

// ===== sv/card_number_luhn_brand_check.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_brand_check
// Converts a binary card number to decimal with a shift-and-add-3 unit,
// then scans the digits one per cycle for count, leading digits and the
// Luhn mod-10 sum, and reports the brand.
// ----------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  ----------------------
//  input     in_card_number                         start && !busy
//  result    out_brand, out_digit_count             out_valid, one cycle
//
//  An item passes through the shift-and-add-3 loop (one input bit per
//  cycle), the digit scan (one digit per cycle) and the ST_DONE state,
//  which forms the brand for the result strobe.
//  busy is high from the cycle after accept through the ST_DONE state and
//  is low during the strobe; a new item may be accepted at the edge that
//  ends the strobe cycle, so an item is not taken before the last is through.
//  rst_n clears the sequencer and the strobe. The receiver cannot stall.
//
module card_number_luhn_brand_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [clbc_pkg::CARD_W-1:0]   in_card_number,
  output logic                          out_valid,
  output logic [clbc_pkg::BRAND_W-1:0]  out_brand,
  output logic [clbc_pkg::COUNT_W-1:0]  out_digit_count
);
  import clbc_pkg::*;

  clbc_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CARD_W-1:0]    bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [3:0]           sum_r, sum_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [3:0]           lead_r, lead_nxt;
  logic [3:0]           next_r, next_nxt;
  logic [3:0]           prev_r, prev_nxt;
  logic                 out_valid_r, out_valid_nxt;
  brand_t               out_brand_r, out_brand_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           dig;
  logic [4:0]           dig_w;
  logic [4:0]           sum_add;
  logic                 is_amex, is_visa, is_mc;
  brand_t               brand_c;

  // add-3 correction on every digit lane
  always_comb begin
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // Luhn weight on the current digit: double odd positions, fold above nine
  always_comb begin
    dig = bcd_r[3:0];
    if (cnt_r[0]) begin
      dig_w = {dig, 1'b0};
      if (dig_w > 5'd9) begin
        dig_w = dig_w - 5'd9;
      end
    end else begin
      dig_w = {1'b0, dig};
    end
    sum_add = {1'b0, sum_r} + dig_w;
    if (sum_add >= 5'd10) begin
      sum_add = sum_add - 5'd10;
    end
  end

  always_comb begin
    is_amex = (count_r == LEN_AMEX) && (lead_r == 4'd3) &&
              ((next_r == 4'd4) || (next_r == 4'd7));
    is_visa = ((count_r == LEN_VISA_SHORT) || (count_r == LEN_LONG)) &&
              (lead_r == 4'd4);
    is_mc   = (count_r == LEN_LONG) && (lead_r == 4'd5) &&
              (next_r >= 4'd1) && (next_r <= 4'd5);
    if (sum_r != 4'd0) begin
      brand_c = BRAND_INVALID;
    end else if (is_amex) begin
      brand_c = BRAND_AMEX;
    end else if (is_visa) begin
      brand_c = BRAND_VISA;
    end else if (is_mc) begin
      brand_c = BRAND_MC;
    end else begin
      brand_c = BRAND_INVALID;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    lead_nxt      = lead_r;
    next_nxt      = next_r;
    prev_nxt      = prev_r;
    out_valid_nxt = 1'b0;
    out_brand_nxt = out_brand_r;
    out_count_nxt = out_count_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CONV;
          cnt_nxt   = '0;
          bin_nxt   = in_card_number;
          bcd_nxt   = '0;
          sum_nxt   = '0;
          count_nxt = COUNT_W'(1);
          lead_nxt  = '0;
          next_nxt  = '0;
          prev_nxt  = '0;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[CARD_W-1]};
        bin_nxt = {bin_r[CARD_W-2:0], 1'b0};
        if (cnt_r == CONV_LAST) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        sum_nxt  = sum_add[3:0];
        prev_nxt = dig;
        bcd_nxt  = {4'd0, bcd_r[BCD_W-1:4]};
        // track the highest nonzero digit and the one below it
        if (dig != 4'd0) begin
          count_nxt = cnt_r[COUNT_W-1:0] + 1'b1;
          lead_nxt  = dig;
          next_nxt  = prev_r;
        end
        if (cnt_r == SCAN_LAST) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_brand_nxt = brand_c;
        out_count_nxt = count_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    sum_r       <= sum_nxt;
    count_r     <= count_nxt;
    lead_r      <= lead_nxt;
    next_r      <= next_nxt;
    prev_r      <= prev_nxt;
    out_brand_r <= out_brand_nxt;
    out_count_r <= out_count_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_brand       = out_brand_r;
  assign out_digit_count = out_count_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(state_r == ST_DONE)))
    else $error("result strobe without finishing an item");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_count != 5'd0) && (out_digit_count <= 5'd17)))
    else $error("digit count out of range");

  a_brand_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_brand != BRAND_INVALID)) |->
      ((out_digit_count == LEN_VISA_SHORT) || (out_digit_count == LEN_AMEX) ||
       (out_digit_count == LEN_LONG)))
    else $error("brand reported for a length that has none");
`endif

endmodule
